>>> rtl/ipv4p_pkg.sv
// shared types and constants for the dotted-decimal ipv4 parser
package ipv4p_pkg;

  // character codes
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // octet limits
  localparam logic [8:0]  OCTET_LIMIT     = 9'd256;
  localparam logic [11:0] OCTET_LIMIT_EXT = 12'd256;
  localparam logic [1:0]  LAST_OCTET      = 2'd3;

  // bit count masks
  localparam logic [31:0] NIBBLE_MASK_3 = 32'h7777_7777;
  localparam logic [31:0] BYTE_MASK_LOW = 32'h0F0F_0F0F;

  // finished string record handed from front to back
  typedef struct packed {
    logic [31:0] address;
    logic        parsed;
    logic        exact;
  } rec_t;

  // number of set bits in a 32-bit word, nibble sums then byte tree
  function automatic logic [5:0] count_ones(input logic [31:0] v);
    logic [31:0] n;
    logic [31:0] m;
    logic [31:0] b;
    logic [5:0]  s;
    n = (v >> 1) & NIBBLE_MASK_3;
    m = v - n;
    n = (n >> 1) & NIBBLE_MASK_3;
    m = m - n;
    n = (n >> 1) & NIBBLE_MASK_3;
    m = m - n;
    b = (m + (m >> 4)) & BYTE_MASK_LOW;
    s = 6'(b[7:0]) + 6'(b[15:8]) + 6'(b[23:16]) + 6'(b[31:24]);
    return s;
  endfunction

endpackage

>>> rtl/ipv4p_front.sv
// character scanner: builds octets and closes out a record on the last character
module ipv4p_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        character,
  input  logic              last,
  output ipv4p_pkg::rec_t   rec
);

  logic [1:0]  idx_r, idx_nxt;
  logic [8:0]  ov_r, ov_nxt;
  logic        ds_r, ds_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        fail_r, fail_nxt;
  logic        cmp_r, cmp_nxt;
  logic        trl_r, trl_nxt;
  logic        term_r, term_nxt;

  logic        is_digit;
  logic        close_ok;
  logic [11:0] prod;
  logic [8:0]  sat;
  logic        fin_ok;
  logic        fin_fail;
  logic        fin_cmp;
  logic [31:0] fin_acc;
  logic        parsed;

  // digit accumulate with sticky saturation
  always_comb begin
    is_digit = (character >= ipv4p_pkg::CHAR_ZERO) && (character <= ipv4p_pkg::CHAR_NINE);
    close_ok = ds_r && (ov_r < ipv4p_pkg::OCTET_LIMIT);
    prod     = ({3'b000, ov_r} << 3) + ({3'b000, ov_r} << 1)
               + {8'h00, 4'(character - ipv4p_pkg::CHAR_ZERO)};
    sat      = (prod > ipv4p_pkg::OCTET_LIMIT_EXT) ? ipv4p_pkg::OCTET_LIMIT : prod[8:0];
  end

  // per character state update
  always_comb begin
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    ds_nxt   = ds_r;
    acc_nxt  = acc_r;
    fail_nxt = fail_r;
    cmp_nxt  = cmp_r;
    trl_nxt  = trl_r;
    term_nxt = term_r;
    if (!(term_r || fail_r)) begin
      if (character == ipv4p_pkg::CHAR_NUL) begin
        term_nxt = 1'b1;
      end else if (cmp_r) begin
        trl_nxt = 1'b1;
      end else if (is_digit) begin
        ov_nxt = sat;
        ds_nxt = 1'b1;
      end else if (idx_r != ipv4p_pkg::LAST_OCTET) begin
        if ((character == ipv4p_pkg::CHAR_DOT) && close_ok) begin
          acc_nxt = {acc_r[23:0], ov_r[7:0]};
          ov_nxt  = '0;
          ds_nxt  = 1'b0;
          idx_nxt = idx_r + 2'd1;
        end else begin
          fail_nxt = 1'b1;
        end
      end else if (close_ok) begin
        acc_nxt = {acc_r[23:0], ov_r[7:0]};
        ov_nxt  = '0;
        ds_nxt  = 1'b0;
        cmp_nxt = 1'b1;
        trl_nxt = 1'b1;
      end else begin
        fail_nxt = 1'b1;
      end
    end
  end

  // end of string: close a pending fourth octet and form the record
  always_comb begin
    fin_ok   = ds_nxt && (ov_nxt < ipv4p_pkg::OCTET_LIMIT);
    fin_fail = fail_nxt;
    fin_cmp  = cmp_nxt;
    fin_acc  = acc_nxt;
    if (!fail_nxt && !cmp_nxt && (idx_nxt == ipv4p_pkg::LAST_OCTET)) begin
      if (fin_ok) begin
        fin_cmp = 1'b1;
        fin_acc = {acc_nxt[23:0], ov_nxt[7:0]};
      end else begin
        fin_fail = 1'b1;
      end
    end
    parsed      = !fin_fail && fin_cmp;
    rec.parsed  = parsed;
    rec.exact   = parsed && !trl_nxt;
    rec.address = parsed ? fin_acc : 32'h0;
  end

  // scanner state, cleared after every string
  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last)) begin
      idx_r  <= '0;
      ov_r   <= '0;
      ds_r   <= 1'b0;
      acc_r  <= '0;
      fail_r <= 1'b0;
      cmp_r  <= 1'b0;
      trl_r  <= 1'b0;
      term_r <= 1'b0;
    end else if (acc) begin
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
      ds_r   <= ds_nxt;
      acc_r  <= acc_nxt;
      fail_r <= fail_nxt;
      cmp_r  <= cmp_nxt;
      trl_r  <= trl_nxt;
      term_r <= term_nxt;
    end
  end

endmodule

>>> rtl/ipv4p_queue.sv
// short record queue between scanner and result stage
module ipv4p_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ipv4p_pkg::rec_t push_rec,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output ipv4p_pkg::rec_t pop_rec
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ipv4p_pkg::rec_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  assign full      = (cnt_r == CntW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_rec   = mem[rd_ptr_r];

endmodule

>>> rtl/ipv4p_back.sv
// result stage: bit count, mask check and output register
module ipv4p_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  ipv4p_pkg::rec_t q_rec,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_address,
  output logic            out_parsed,
  output logic            out_exact,
  output logic [5:0]      out_ones_count,
  output logic            out_low_ones_mask
);

  logic        valid_r;
  logic [31:0] addr_r;
  logic        parsed_r;
  logic        exact_r;
  logic [5:0]  ones_r;
  logic        mask_r;
  logic        mask_nxt;
  logic [5:0]  ones_nxt;

  // take a record whenever the output register is free or draining
  assign q_pop = q_valid && (!valid_r || out_ready);

  always_comb begin
    ones_nxt = ipv4p_pkg::count_ones(q_rec.address);
    mask_nxt = q_rec.exact && ((q_rec.address & (q_rec.address + 32'd1)) == 32'h0);
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      addr_r   <= q_rec.address;
      parsed_r <= q_rec.parsed;
      exact_r  <= q_rec.exact;
      ones_r   <= ones_nxt;
      mask_r   <= mask_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_address       = addr_r;
  assign out_parsed        = parsed_r;
  assign out_exact         = exact_r;
  assign out_ones_count    = ones_r;
  assign out_low_ones_mask = mask_r;

endmodule

>>> rtl/ipv4_dotted_decimal_parser.sv
// dotted-decimal ipv4 parser, one text character per transaction
// throughput: one character per cycle; the scanner only stalls when the record queue is full
// a finished record is written to the record queue, then to the output register that drives out_valid
// the record queue (QUEUE_DEPTH entries) lets the scanner run while a result waits
// reset (rst_n low, synchronous) clears scanner state, queue and output valid
module ipv4_dotted_decimal_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_character,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_address,
  output logic        out_parsed,
  output logic        out_exact,
  output logic [5:0]  out_ones_count,
  output logic        out_low_ones_mask
);

  logic            in_acc;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  ipv4p_pkg::rec_t front_rec;
  ipv4p_pkg::rec_t q_rec;

  // input transaction
  assign in_ready = !q_full;
  assign in_acc   = in_valid && in_ready;

  ipv4p_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .character (in_character),
    .last      (in_last),
    .rec       (front_rec)
  );

  ipv4p_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc && in_last),
    .push_rec  (front_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_rec   (q_rec)
  );

  ipv4p_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_rec             (q_rec),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_address       (out_address),
    .out_parsed        (out_parsed),
    .out_exact         (out_exact),
    .out_ones_count    (out_ones_count),
    .out_low_ones_mask (out_low_ones_mask)
  );

endmodule
